// ===== rtl/utfbc_pkg.sv =====
// Shared types, constants and the UTF-8 lead byte decoder for the truncating copy core.
`default_nettype none

package utfbc_pkg;

    localparam int UTFBC_LEN_WIDTH   = 16;
    localparam int UTFBC_QUEUE_DEPTH = 4;
    localparam int UTFBC_CAP_WIDTH   = 16;
    localparam int UTFBC_OUT_LEN_W   = 16;

    localparam logic [UTFBC_CAP_WIDTH-1:0] UTFBC_CAP_RESET = 16'd256;

    // Lead byte masks and match patterns
    localparam logic [7:0] UTFBC_ASCII_LIMIT = 8'h80;
    localparam logic [7:0] UTFBC_MASK2       = 8'hE0;
    localparam logic [7:0] UTFBC_LEAD2       = 8'hC0;
    localparam logic [7:0] UTFBC_MASK3       = 8'hF0;
    localparam logic [7:0] UTFBC_LEAD3       = 8'hE0;
    localparam logic [7:0] UTFBC_MASK4       = 8'hF8;
    localparam logic [7:0] UTFBC_LEAD4       = 8'hF0;

    localparam logic [2:0] UTFBC_SEQ_NONE = 3'd0;
    localparam logic [2:0] UTFBC_SEQ_1    = 3'd1;
    localparam logic [2:0] UTFBC_SEQ_2    = 3'd2;
    localparam logic [2:0] UTFBC_SEQ_3    = 3'd3;
    localparam logic [2:0] UTFBC_SEQ_4    = 3'd4;

    // One queued job: up to four bytes to emit, or one terminator word
    typedef struct packed {
        logic [2:0]                     cnt;
        logic                           term;
        logic [3:0][7:0]                bytes;
        logic [UTFBC_OUT_LEN_W-1:0]     len;
    } cmd_t;

    function automatic logic [2:0] seq_size(input logic [7:0] lead);
        logic [2:0] n;
        if (lead < UTFBC_ASCII_LIMIT) begin
            n = UTFBC_SEQ_1;
        end else if ((lead & UTFBC_MASK2) == UTFBC_LEAD2) begin
            n = UTFBC_SEQ_2;
        end else if ((lead & UTFBC_MASK3) == UTFBC_LEAD3) begin
            n = UTFBC_SEQ_3;
        end else if ((lead & UTFBC_MASK4) == UTFBC_LEAD4) begin
            n = UTFBC_SEQ_4;
        end else begin
            n = UTFBC_SEQ_1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_boundary_truncating_copy_core.sv =====
// Top level of the UTF-8 boundary-respecting truncating copy core.
//
// Usage:
//   Source bytes come in on src_valid/src_ready/src_byte, one word per byte;
//   a zero byte ends the string. Copied bytes leave on out_valid/out_ready
//   with out_byte; the last word of each string is the terminator
//   (is_terminator high, out_byte zero, copied_len = bytes copied).
//   The capacity register (bytes including the terminator) is written over
//   cfg_valid/cfg_ready/cfg_data; cfg_ready is always high. Write it only
//   while the core is idle. It resets to 256.
//
// Timing:
//   Each emit job passes through the job queue and then the output register.
//   The front end takes one byte a cycle while the queue has room; the
//   emitter puts out one word a cycle unless the receiver stalls, so a
//   sequence of n bytes yields n words. A four-deep queue absorbs the burst
//   of a multi-byte sequence. When the receiver stalls, the output register
//   holds, the queue fills, and src_ready drops once it is full. Reset
//   empties the queue, drops any open sequence and starts a new string.
`default_nettype none

module utf8_boundary_truncating_copy_core
    import utfbc_pkg::*;
#(
    parameter int LEN_WIDTH   = UTFBC_LEN_WIDTH,
    parameter int QUEUE_DEPTH = UTFBC_QUEUE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [UTFBC_CAP_WIDTH-1:0] cfg_data,
    input  wire logic                       src_valid,
    output logic                            src_ready,
    input  wire logic [7:0]                 src_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [7:0]                      out_byte,
    output logic                            is_terminator,
    output logic [UTFBC_OUT_LEN_W-1:0]      copied_len
);

    logic [UTFBC_CAP_WIDTH-1:0] capacity_reg;
    logic                       front_valid;
    cmd_t                       front_cmd;
    logic                       queue_ready;
    logic                       queue_valid;
    cmd_t                       queue_cmd;
    logic                       queue_pop;

    // Configuration: always ready, capacity takes effect on the next byte
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= UTFBC_CAP_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    // Classify bytes and decide what each one emits
    utfbc_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_byte  (src_byte),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (queue_ready)
    );

    // Decouple the front end from output stalls
    utfbc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_ready (queue_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_data   (queue_cmd)
    );

    // Serialize jobs into output words
    utfbc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_valid),
        .cmd           (queue_cmd),
        .cmd_pop       (queue_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .copied_len    (copied_len)
    );

endmodule

`default_nettype wire

// ===== rtl/utfbc_front.sv =====
// Front end: take source bytes, gather UTF-8 sequences, check fit, queue emit jobs.
`default_nettype none

module utfbc_front
    import utfbc_pkg::*;
#(
    parameter int LEN_WIDTH = UTFBC_LEN_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [UTFBC_CAP_WIDTH-1:0] capacity,
    input  wire logic                       src_valid,
    output logic                            src_ready,
    input  wire logic [7:0]                 src_byte,
    output logic                            cmd_valid,
    output cmd_t                            cmd,
    input  wire logic                       cmd_ready
);

    localparam int CW = ((LEN_WIDTH > UTFBC_CAP_WIDTH) ? LEN_WIDTH : UTFBC_CAP_WIDTH) + 1;
    localparam logic [CW-1:0] LEN_LIMIT = CW'(1) << LEN_WIDTH;

    logic [2:0][7:0]        pend_reg, pend_next;
    logic [2:0]             expected_reg, expected_next;
    logic [2:0]             collected_reg, collected_next;
    logic [LEN_WIDTH-1:0]   out_len_reg, out_len_next;
    logic                   stopped_reg, stopped_next;

    logic                   accept;
    logic [2:0]             lead_n;
    logic [2:0]             fit_n;
    logic [2:0]             coll_inc;
    logic [CW-1:0]          cap_ext;
    logic [CW-1:0]          cap_eff;
    logic [CW-1:0]          sum;
    logic [CW-1:0]          len_ext;
    logic                   fits;

    assign src_ready = cmd_ready;
    assign accept    = src_valid && cmd_ready;
    assign lead_n    = seq_size(src_byte);
    assign fit_n     = (expected_reg == UTFBC_SEQ_NONE) ? UTFBC_SEQ_1 : expected_reg;
    assign coll_inc  = collected_reg + 3'd1;
    assign cap_ext   = CW'(capacity);
    assign cap_eff   = (cap_ext > LEN_LIMIT) ? LEN_LIMIT : cap_ext;
    assign sum       = CW'(out_len_reg) + CW'(fit_n);
    assign fits      = sum < cap_eff;
    assign len_ext   = CW'(out_len_reg);

    always_comb
    begin
        pend_next      = pend_reg;
        expected_next  = expected_reg;
        collected_next = collected_reg;
        out_len_next   = out_len_reg;
        stopped_next   = stopped_reg;
        cmd_valid      = 1'b0;
        cmd            = '0;

        if (accept) begin
            if (src_byte == 8'd0) begin
                // terminator: report length and open a new string
                cmd_valid      = 1'b1;
                cmd.cnt        = UTFBC_SEQ_1;
                cmd.term       = 1'b1;
                cmd.len        = len_ext[UTFBC_OUT_LEN_W-1:0];
                expected_next  = UTFBC_SEQ_NONE;
                collected_next = 3'd0;
                out_len_next   = '0;
                stopped_next   = 1'b0;
            end else if (!stopped_reg) begin
                if (expected_reg == UTFBC_SEQ_NONE) begin
                    if (lead_n == UTFBC_SEQ_1) begin
                        if (fits) begin
                            cmd_valid      = 1'b1;
                            cmd.cnt        = UTFBC_SEQ_1;
                            cmd.bytes[0]   = src_byte;
                            out_len_next   = sum[LEN_WIDTH-1:0];
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end else begin
                        pend_next[0]   = src_byte;
                        expected_next  = lead_n;
                        collected_next = 3'd1;
                    end
                end else begin
                    if (collected_reg < 3'd3) begin
                        pend_next[collected_reg[1:0]] = src_byte;
                    end
                    collected_next = coll_inc;
                    if (coll_inc >= expected_reg) begin
                        expected_next  = UTFBC_SEQ_NONE;
                        collected_next = 3'd0;
                        if (!fits) begin
                            stopped_next = 1'b1;
                        end else begin
                            cmd_valid    = 1'b1;
                            cmd.cnt      = expected_reg;
                            cmd.bytes[0] = pend_reg[0];
                            cmd.bytes[1] = (expected_reg == UTFBC_SEQ_2) ? src_byte : pend_reg[1];
                            cmd.bytes[2] = (expected_reg == UTFBC_SEQ_3) ? src_byte : pend_reg[2];
                            cmd.bytes[3] = src_byte;
                            out_len_next = sum[LEN_WIDTH-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expected_reg  <= UTFBC_SEQ_NONE;
            collected_reg <= 3'd0;
            out_len_reg   <= '0;
            stopped_reg   <= 1'b0;
        end else begin
            expected_reg  <= expected_next;
            collected_reg <= collected_next;
            out_len_reg   <= out_len_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== rtl/utfbc_fifo.sv =====
// Short job queue between the front end and the emitter.
`default_nettype none

module utfbc_fifo
    import utfbc_pkg::*;
#(
    parameter int DEPTH = UTFBC_QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       push_ready,
    input  wire cmd_t  push_data,
    output logic       pop_valid,
    input  wire logic  pop,
    output cmd_t       pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]    count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utfbc_back.sv =====
// Back end: walk jobs into the output register one byte a cycle unless stalled.
`default_nettype none

module utfbc_back
    import utfbc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    input  wire cmd_t                       cmd,
    output logic                            cmd_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [7:0]                      out_byte,
    output logic                            is_terminator,
    output logic [UTFBC_OUT_LEN_W-1:0]      copied_len
);

    logic [1:0]                     idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg;
    logic                           term_reg;
    logic [UTFBC_OUT_LEN_W-1:0]     len_reg;
    logic                           load;
    logic                           last;

    assign load    = cmd_valid && (!out_valid_reg || out_ready);
    assign last    = ({1'b0, idx_reg} == (cmd.cnt - 3'd1));
    assign cmd_pop = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= cmd.bytes[idx_reg];
            term_reg     <= cmd.term;
            len_reg      <= cmd.len;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_terminator = term_reg;
    assign copied_len    = len_reg;

endmodule

`default_nettype wire

// ===== rtl/utfbc_checker.sv =====
// Port-level checks for the truncating copy core, bound to the top level.
`default_nettype none

module utfbc_checker
    import utfbc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [7:0]                 out_byte,
    input  wire logic                       is_terminator,
    input  wire logic [UTFBC_OUT_LEN_W-1:0] copied_len
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(is_terminator) && $stable(copied_len))
        else $error("output word changed while stalled");

    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_terminator |-> out_byte == 8'd0)
        else $error("terminator carries a nonzero byte");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_terminator |-> copied_len == '0)
        else $error("data word carries a length");

    a_len_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_terminator |-> copied_len != {UTFBC_OUT_LEN_W{1'b1}})
        else $error("copied length leaves no room for the terminator");

endmodule

bind utf8_boundary_truncating_copy_core utfbc_checker u_utfbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .copied_len    (copied_len)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the UTF-8 boundary-respecting truncating copy core.
`timescale 1ns / 1ps

module tb_top;
    import utfbc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SRC_TARGET   = 260;

    // One output word as the core should present it
    typedef struct packed {
        logic [7:0]                 data;
        logic                       term;
        logic [UTFBC_OUT_LEN_W-1:0] len;
    } copy_word_t;

    // Directed strings: every sequence size, invalid leads, a sequence cut by
    // the zero, and an empty string, all at the reset capacity
    localparam logic [7:0] DIR_RESET_CAP [0:18] = '{
        8'h01, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hF8, 8'h00,
        8'hE2, 8'h82, 8'h00,
        8'h00
    };
    // With a capacity of four the pair cannot fit: copying stops and the
    // trailing byte is dropped
    localparam logic [7:0] DIR_SMALL_CAP [0:5] = '{
        8'h41, 8'h42, 8'hC2, 8'hA9, 8'h43, 8'h00
    };

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [UTFBC_CAP_WIDTH-1:0] cfg_data  = '0;
    logic                       src_valid = 1'b0;
    logic                       src_ready;
    logic [7:0]                 src_byte  = 8'h00;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [7:0]                 out_byte;
    logic                       is_terminator;
    logic [UTFBC_OUT_LEN_W-1:0] copied_len;

    // Predicted copy state
    logic [7:0]                 seq_buf [0:2];
    logic [2:0]                 seq_need    = UTFBC_SEQ_NONE;
    logic [2:0]                 seq_have    = 3'd0;
    logic [UTFBC_OUT_LEN_W-1:0] copy_cnt    = '0;
    logic                       copy_halted = 1'b0;
    logic [UTFBC_CAP_WIDTH-1:0] cap_now     = UTFBC_CAP_RESET;

    copy_word_t copied_q [$];
    logic [7:0] src_q [$];

    // Handshake bookkeeping between the monitor and the drivers
    bit src_taken    = 1'b0;
    bit out_taken    = 1'b0;
    bit src_pause    = 1'b0;
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_req     = 1'b0;
    int hold_cnt     = 0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int src_total    = 0;
    int out_words    = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    utf8_boundary_truncating_copy_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .src_valid     (src_valid),
        .src_ready     (src_ready),
        .src_byte      (src_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .copied_len    (copied_len)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Copy predictor
    // ------------------------------------------------------------------

    // Size a sequence from its lead byte; anything that is not a valid lead
    // counts as a single byte
    function automatic logic [2:0] lead_len(input logic [7:0] lead);
        if (lead < UTFBC_ASCII_LIMIT)
            return UTFBC_SEQ_1;
        if ((lead & UTFBC_MASK2) == UTFBC_LEAD2)
            return UTFBC_SEQ_2;
        if ((lead & UTFBC_MASK3) == UTFBC_LEAD3)
            return UTFBC_SEQ_3;
        if ((lead & UTFBC_MASK4) == UTFBC_LEAD4)
            return UTFBC_SEQ_4;
        return UTFBC_SEQ_1;
    endfunction

    // A sequence fits only if it and the terminator stay inside the capacity
    function automatic bit room_for(input logic [2:0] n);
        return ({1'b0, copy_cnt} + {14'd0, n}) < {1'b0, cap_now};
    endfunction

    // Advance the predicted state by one source byte and queue the words
    // that byte releases
    task automatic copy_step(input logic [7:0] b);
        int i;
        logic [2:0] n;
        if (b == 8'h00) begin
            // Terminator: drop any open sequence and start a new string
            copied_q.push_back(copy_word_t'{8'h00, 1'b1, copy_cnt});
            seq_need    = UTFBC_SEQ_NONE;
            seq_have    = 3'd0;
            copy_cnt    = '0;
            copy_halted = 1'b0;
        end else if (!copy_halted) begin
            if (seq_need == UTFBC_SEQ_NONE) begin
                n = lead_len(b);
                if (n == UTFBC_SEQ_1) begin
                    if (room_for(UTFBC_SEQ_1)) begin
                        copied_q.push_back(copy_word_t'{b, 1'b0, '0});
                        copy_cnt = copy_cnt + 1'b1;
                    end else begin
                        copy_halted = 1'b1;
                    end
                end else begin
                    seq_buf[0] = b;
                    seq_need   = n;
                    seq_have   = 3'd1;
                end
            end else begin
                if (seq_have < 3'd3)
                    seq_buf[seq_have[1:0]] = b;
                seq_have = seq_have + 3'd1;
                if (seq_have == seq_need) begin
                    if (!room_for(seq_need)) begin
                        copy_halted = 1'b1;
                    end else begin
                        for (i = 0; i < 3 && i < seq_need; i++)
                            copied_q.push_back(copy_word_t'{seq_buf[i], 1'b0, '0});
                        if (seq_need == UTFBC_SEQ_4)
                            copied_q.push_back(copy_word_t'{b, 1'b0, '0});
                        copy_cnt = copy_cnt + {13'd0, seq_need};
                    end
                    seq_need = UTFBC_SEQ_NONE;
                    seq_have = 3'd0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_src(input logic [7:0] b);
        src_q.push_back(b);
        src_total++;
    endtask

    function automatic logic [7:0] random_lead(input int n);
        if (n == 2)
            return UTFBC_LEAD2 | 8'($urandom_range(0, 31));
        if (n == 3)
            return UTFBC_LEAD3 | 8'($urandom_range(0, 15));
        return UTFBC_LEAD4 | 8'($urandom_range(0, 7));
    endfunction

    // Mostly proper continuation bytes; now and then any nonzero byte, since
    // the core does not check them
    function automatic logic [7:0] random_cont();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return UTFBC_ASCII_LIMIT | 8'($urandom_range(0, 63));
    endfunction

    // Queue one zero-terminated string: mostly well-formed characters, with
    // some invalid leads, noise and sequences cut short by the zero
    task automatic add_string(input int max_chars);
        int  n_chars;
        int  kind;
        int  k;
        int  j;
        int  seq_n;
        int  cut;
        bit  cut_short;
        n_chars   = $urandom_range(0, max_chars);
        cut_short = 1'b0;
        for (k = 0; k < n_chars && !cut_short; k++) begin
            kind = $urandom_range(0, 15);
            if (kind < 6 || kind == 15) begin
                push_src(8'($urandom_range(1, 127)));
            end else if (kind < 12) begin
                seq_n = (kind < 8) ? 2 : (kind < 10) ? 3 : 4;
                push_src(random_lead(seq_n));
                for (j = 1; j < seq_n; j++)
                    push_src(random_cont());
            end else if (kind == 12) begin
                if ($urandom_range(0, 1) != 0)
                    push_src(8'($urandom_range(128, 191)));
                else
                    push_src(8'($urandom_range(248, 255)));
            end else if (kind == 13) begin
                push_src(8'($urandom_range(1, 255)));
            end else begin
                // Open a sequence and end the string before it completes
                seq_n = $urandom_range(2, 4);
                push_src(random_lead(seq_n));
                cut = $urandom_range(0, seq_n - 2);
                for (j = 0; j < cut; j++)
                    push_src(random_cont());
                cut_short = 1'b1;
            end
        end
        push_src(8'h00);
    endtask

    // Hold until no source word is pending and every predicted word has
    // come, then let the core settle
    task automatic wait_idle();
        while (src_q.size() != 0 || src_valid || copied_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register; call only while the core is idle
    task automatic write_capacity(input logic [UTFBC_CAP_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the output
    // word first, then predict from the accepted source word.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        copy_word_t w;
        if (out_valid && out_ready) begin
            out_words++;
            if (copied_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("word %0d unexpected: byte %02h term %0b len %0d",
                             out_words, out_byte, is_terminator, copied_len);
            end else begin
                w = copied_q.pop_front();
                if (out_byte !== w.data || is_terminator !== w.term ||
                    copied_len !== w.len) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("word %0d mismatch: got byte %02h term %0b len %0d, %s %02h term %0b len %0d",
                                 out_words, out_byte, is_terminator, copied_len,
                                 "want byte", w.data, w.term, w.len);
                end
            end
            out_taken = 1'b1;
        end
        if (src_valid && src_ready) begin
            copy_step(src_byte);
            src_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Source driver: drop valid after acceptance, wait out the drawn gap,
    // then offer the next queued byte. Valid is assigned once per edge.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : src_driver
        logic next_valid;
        if (rst_n) begin
            next_valid = src_valid;
            if (src_taken) begin
                src_taken  = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (!src_pause && src_q.size() != 0) begin
                    src_byte  <= src_q.pop_front();
                    next_valid = 1'b1;
                    src_gap    = src_idle_on ? $urandom_range(0, 11) : 0;
                end
            end
            src_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Sink driver: stall a drawn number of cycles after each word, and
    // hold ready low for the whole of a long hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : sink_driver
        if (rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                sink_gap  = sink_idle_on ? $urandom_range(0, 11) : 0;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end
            out_ready <= (sink_gap == 0) && (hold_cnt == 0);
        end
    end

    // Long receiver hold-off, counted here so it runs on its own
    always @(posedge clk) begin : sink_hold
        if (hold_cnt != 0) begin
            hold_cnt--;
        end else if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
    end

    // Watchdog: end the run if it never drains
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("** utf8_boundary_truncating_copy_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k;
        int ph;
        logic [UTFBC_CAP_WIDTH-1:0] cap_pick;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity, no idling
        foreach (DIR_RESET_CAP[k])
            push_src(DIR_RESET_CAP[k]);
        wait_idle();

        // Stop on a sequence that does not fit, ignore the rest of the string
        write_capacity(16'd4);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (DIR_SMALL_CAP[k])
            push_src(DIR_SMALL_CAP[k]);
        wait_idle();

        // Smallest capacity: only terminators with zero length come out
        write_capacity(16'd1);
        for (k = 0; k < 4; k++)
            add_string(4);
        wait_idle();

        // Largest capacity, then a long receiver hold-off while the sender
        // keeps pushing back-to-back bytes so the core fills and stalls
        write_capacity(16'hFFFF);
        for (k = 0; k < 4; k++)
            add_string(8);
        wait_idle();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        for (k = 0; k < 40; k++)
            push_src(8'($urandom_range(1, 127)));
        push_src(8'h00);
        wait_idle();

        // Random phases, mostly small capacities so truncation is common
        ph = 0;
        while (src_total < SRC_TARGET) begin
            ph++;
            if ($urandom_range(0, 4) == 0)
                cap_pick = 16'($urandom_range(25, 65535));
            else
                cap_pick = 16'($urandom_range(1, 24));
            write_capacity(cap_pick);
            src_idle_on  = $urandom_range(0, 2) != 0;
            sink_idle_on = $urandom_range(0, 2) != 0;
            for (k = 0; k < 5; k++)
                add_string(12);
            if (ph == 1) begin
                // Pause the sender mid-stream until every word has drained
                while (src_q.size() > 8)
                    @(posedge clk);
                src_pause = 1'b1;
                while (src_valid || copied_q.size() != 0)
                    @(posedge clk);
                src_pause = 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (copied_q.size() != 0) begin
            err_cnt += copied_q.size();
            $display("%0d predicted words never came", copied_q.size());
        end

        if (err_cnt == 0)
            $display("** utf8_boundary_truncating_copy_core: PASSED **");
        else
            $display("** utf8_boundary_truncating_copy_core: FAILED **");
        $finish;
    end

endmodule

// ===== utf8_boundary_truncating_copy_core.f =====
rtl/utfbc_pkg.sv
rtl/utfbc_front.sv
rtl/utfbc_fifo.sv
rtl/utfbc_back.sv
rtl/utf8_boundary_truncating_copy_core.sv
rtl/utfbc_checker.sv
sim/tb_top.sv
